### src/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// Shared types and constants of the sliding window min/max block: register
// map, configuration port widths and the window size register format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int INDEX_W = ADDR_W - 2;
  localparam int WS_W    = 7;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [INDEX_W-1:0] reg_index_t;
  typedef logic [WS_W-1:0]    win_t;

  localparam reg_index_t REG_WINDOW_SIZE = reg_index_t'(0);
  localparam win_t       WS_RESET        = win_t'(1);

endpackage

`default_nettype wire

### src/swmm_regs.sv
// ----------------------------------------------------------------------------
// swmm_regs
// APB-style configuration register file holding the window size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swmm_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire swmm_pkg::addr_t paddr,
  input  wire swmm_pkg::data_t pwdata,
  output swmm_pkg::data_t     prdata,
  output logic                pready,
  output swmm_pkg::win_t      window_size
);
  import swmm_pkg::*;

  logic hit;

  assign hit    = (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      window_size <= pwdata[WS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = DATA_W'(window_size);
    end
  end

endmodule

`default_nettype wire

### src/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// One cell of the prefix chain: holds the minimum and maximum of the most
// recent samples up to its depth, taking its neighbour's pair on each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swmm_cell #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           load,
  input  wire logic                           tap,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prev_min,
  input  wire logic signed [SAMPLE_WIDTH-1:0] prev_max,
  output logic signed [SAMPLE_WIDTH-1:0]      cur_min,
  output logic signed [SAMPLE_WIDTH-1:0]      cur_max,
  output logic [SAMPLE_WIDTH-1:0]             sel_min,
  output logic [SAMPLE_WIDTH-1:0]             sel_max
);

  logic signed [SAMPLE_WIDTH-1:0] min_next;
  logic signed [SAMPLE_WIDTH-1:0] max_next;

  always_comb begin
    min_next = (sample < prev_min) ? sample : prev_min;
    max_next = (sample > prev_max) ? sample : prev_max;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_min <= min_next;
      cur_max <= max_next;
    end
  end

  assign sel_min = tap ? min_next : '0;
  assign sel_max = tap ? max_next : '0;

endmodule

`default_nettype wire

### src/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max
// Minimum and maximum of the last window_size samples of a sequence, kept by
// a chain of cells where cell i holds the extremes of the last i+1 samples.
//
//   channel   direction  handshake                  payload
//   request   in         sample_valid/sample_stall  sample, start_of_sequence
//   result    out        result_valid/result_stall window_min, window_max
//   config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// One request per clock unless stalled; a result shows in the next cycle.
// All cells update together on a request; the output register is loaded from
// the cell at depth window_size, clamped to 1..WINDOW_MAX, via a one-hot tap.
// Requests stall only while a result is held by result_stall.
// Synchronous reset clears the window size to 1, the sample count and the
// output valid; the cells need no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_min_max #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           start_of_sequence,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      window_min,
  output logic signed [SAMPLE_WIDTH-1:0]      window_max,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire swmm_pkg::addr_t                paddr,
  input  wire swmm_pkg::data_t                pwdata,
  output swmm_pkg::data_t                     prdata,
  output logic                                pready
);
  import swmm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;

  win_t                           window_size;
  logic [CMP_W-1:0]               ws_wide;
  logic [CNT_W-1:0]               win_eff;
  logic [CNT_W-1:0]               samples_seen;
  logic [CNT_W-1:0]               seen_base;
  logic [CNT_W-1:0]               samples_seen_next;
  logic                           accept;
  logic                           has_result;
  logic [WINDOW_MAX-1:0]          tap;
  logic signed [SAMPLE_WIDTH-1:0] chain_min [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] chain_max [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]        sel_min [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]        sel_max [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0]        pick_min;
  logic [SAMPLE_WIDTH-1:0]        pick_max;

  swmm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  always_comb begin
    ws_wide = CMP_W'(window_size);
    if (ws_wide == '0) begin
      win_eff = CNT_W'(1);
    end else if (ws_wide > CMP_W'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = ws_wide[CNT_W-1:0];
    end
  end

  assign sample_stall = result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  always_comb begin
    seen_base         = start_of_sequence ? '0 : samples_seen;
    samples_seen_next = (seen_base < win_eff) ? seen_base + CNT_W'(1) : win_eff;
    has_result        = (samples_seen_next == win_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (accept) begin
      samples_seen <= samples_seen_next;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] prev_min;
    logic signed [SAMPLE_WIDTH-1:0] prev_max;

    assign tap[i] = (win_eff == CNT_W'(i + 1));

    if (i == 0) begin : g_head
      assign prev_min = sample;
      assign prev_max = sample;
    end else begin : g_link
      assign prev_min = chain_min[i-1];
      assign prev_max = chain_max[i-1];
    end

    swmm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .load     (accept),
      .tap      (tap[i]),
      .sample   (sample),
      .prev_min (prev_min),
      .prev_max (prev_max),
      .cur_min  (chain_min[i]),
      .cur_max  (chain_max[i]),
      .sel_min  (sel_min[i]),
      .sel_max  (sel_max[i])
    );
  end

  always_comb begin
    pick_min = '0;
    pick_max = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      pick_min = pick_min | sel_min[i];
      pick_max = pick_max | sel_max[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= has_result;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      window_min <= pick_min;
      window_max <= pick_max;
    end
  end

endmodule

`default_nettype wire

### src/swmm_checker.sv
// ----------------------------------------------------------------------------
// swmm_checker
// Port-level checks of the sliding window min/max block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swmm_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           sample_valid,
  input wire logic                           sample_stall,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire logic signed [SAMPLE_WIDTH-1:0] window_min,
  input wire logic signed [SAMPLE_WIDTH-1:0] window_max
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(window_min) && $stable(window_max))
    else $error("result changed while stalled");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> window_min <= window_max)
    else $error("window minimum above maximum");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !(sample_valid && !sample_stall) |=> !result_valid)
    else $error("result repeated without a request");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_min_max swmm_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swmm_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .window_min   (window_min),
  .window_max   (window_max)
);

`default_nettype wire
